FILE: design/bounded_substring_search_assert.svh
// Assertion macros used by the checker file of the substring search block.
// Needs only the clock aclk and the active-low reset aresetn in the caller's scope.
`ifndef BOUNDED_SUBSTRING_SEARCH_ASSERT_SVH
`define BOUNDED_SUBSTRING_SEARCH_ASSERT_SVH

// Checked on every rising edge outside reset.
`define BSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define BSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

FILE: design/bss_pkg.sv
// Shared types, codes and helpers of the bounded substring search block.
// No dependencies; used by bss_cell, bounded_substring_search and bss_checker.
package bss_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 64;
    localparam int unsigned LEN_W     = 5;
    localparam int unsigned OUT_W     = 2;
    localparam int unsigned OFFSET_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FOLD_CASE   = 2'd3;

    // Result outcome codes.
    localparam logic [OUT_W-1:0] OUTCOME_FOUND     = 2'd0;
    localparam logic [OUT_W-1:0] OUTCOME_NOT_FOUND = 2'd1;
    localparam logic [OUT_W-1:0] OUTCOME_OVERLONG  = 2'd2;

    localparam logic [BYTE_W-1:0] CHAR_NUL      = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_BIT_MASK = 8'h20;

    typedef logic [BYTE_W-1:0] byte_t;

    // Control handed from the top level to every window cell.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // Folds ASCII upper case to lower case when enabled.
    function automatic byte_t fold_byte(input byte_t b, input logic fold);
        if (fold && (b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) begin
            return b | CASE_BIT_MASK;
        end
        return b;
    endfunction

endpackage

FILE: design/bounded_substring_search.sv
// Bounded substring search: one haystack byte per cycle while the result register is free or drained.
// A result appears on m_tvalid in the cycle after the input transaction that decides it.
// The window cell chain compares the incoming byte combinationally and shifts it in when accepted.
// The output register is released by m_tready in the same cycle it is refilled.
// Reset (synchronous, aresetn low) clears configuration, window, position, decided flag and result valid.
// No clearing pass is needed; the block accepts input in the first cycle after reset.
module bounded_substring_search #(
    parameter int unsigned     NEEDLE_MAX = 16,
    parameter longint unsigned HAY_MAX    = 65536
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bss_pkg::CFG_W-1:0]           cfg_data,
    // Haystack byte stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] hay_byte
    input  logic                                s_tlast,   // buffer_end
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // [15:0] match_offset
    output logic [1:0]                          m_tuser    // [1:0] outcome
);

    // Position counts bytes taken in the current buffer and saturates at HAY_MAX.
    localparam int unsigned POS_W = $clog2(HAY_MAX + 1);
    localparam int unsigned PW1   = POS_W + 1;
    localparam int unsigned OFF_W = (POS_W > bss_pkg::OFFSET_W) ? POS_W : bss_pkg::OFFSET_W;
    localparam logic [POS_W-1:0] HAY_LIM = POS_W'(HAY_MAX);
    localparam logic [bss_pkg::LEN_W-1:0] NMAX_LEN = bss_pkg::LEN_W'(NEEDLE_MAX);

    // Configuration registers.
    logic [bss_pkg::CFG_W-1:0]   needle_lo_reg;
    logic [bss_pkg::CFG_W-1:0]   needle_hi_reg;
    logic [bss_pkg::LEN_W-1:0]   needle_len_reg;
    logic                        fold_reg;

    // Buffer state.
    logic [POS_W-1:0] position_reg, position_next;
    logic             decided_reg, decided_next;

    // Output register.
    logic                          m_valid_reg, m_valid_next;
    logic [bss_pkg::OUT_W-1:0]     outcome_reg, outcome_next;
    logic [bss_pkg::OFFSET_W-1:0]  offset_reg, offset_next;

    logic                         accept;
    logic [bss_pkg::LEN_W-1:0]    n_eff;
    logic                         n_zero;
    logic                         overlong;
    logic                         hay_nul;
    logic                         reached;
    logic                         hit;
    logic                         done;
    logic [bss_pkg::OUT_W-1:0]    outcome_now;
    logic [OFF_W-1:0]             off_full;
    logic [2*bss_pkg::CFG_W-1:0]  needle_vec;
    bss_pkg::byte_t               hay_folded;
    bss_pkg::cell_ctrl_t          cell_ctrl;

    bss_pkg::byte_t               cell_dout  [NEEDLE_MAX];
    logic [NEEDLE_MAX-1:0]        cell_match;

    // Configuration is always ready: the user must write registers only while idle; the block does not enforce it.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needle_lo_reg  <= '0;
            needle_hi_reg  <= '0;
            needle_len_reg <= '0;
            fold_reg       <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                bss_pkg::REG_NEEDLE_LOW:  needle_lo_reg  <= cfg_data;
                bss_pkg::REG_NEEDLE_HIGH: needle_hi_reg  <= cfg_data;
                bss_pkg::REG_NEEDLE_LEN:  needle_len_reg <= cfg_data[bss_pkg::LEN_W-1:0];
                bss_pkg::REG_FOLD_CASE:   fold_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // A new byte is taken whenever the output register is free or being drained.
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign needle_vec = {needle_hi_reg, needle_lo_reg};
    assign n_eff      = (needle_len_reg > NMAX_LEN) ? NMAX_LEN : needle_len_reg;
    assign n_zero     = (n_eff == '0);
    assign overlong   = (position_reg >= HAY_LIM);
    assign hay_nul    = (s_tdata == bss_pkg::CHAR_NUL);
    assign hay_folded = bss_pkg::fold_byte(s_tdata, fold_reg);

    // Enough bytes seen for the needle to fit: position + 1 >= length.
    assign reached  = (PW1'(position_reg) + PW1'(1)) >= PW1'(n_eff);
    assign off_full = OFF_W'(position_reg) + OFF_W'(1) - OFF_W'(n_eff);

    // The window shifts only for a byte that is still being searched.
    assign cell_ctrl.shift = accept && !decided_reg && !n_zero && !overlong && !hay_nul;
    assign cell_ctrl.clear = (accept && s_tlast) || !aresetn;

    // Cell j compares the byte j places back from the newest; for a needle of length n it
    // must equal needle byte n-1-j, so each cell gets its aligned needle byte.
    for (genvar j = 0; j < NEEDLE_MAX; j++) begin : g_cell
        logic [3:0]     nidx;
        logic           active;
        bss_pkg::byte_t need_raw;
        bss_pkg::byte_t din;

        assign active   = (bss_pkg::LEN_W'(j) < n_eff);
        assign nidx     = 4'(n_eff - bss_pkg::LEN_W'(1) - bss_pkg::LEN_W'(j));
        assign need_raw = needle_vec[8*nidx +: 8];

        if (j == 0) begin : g_head
            assign din = hay_folded;
        end else begin : g_link
            assign din = cell_dout[j-1];
        end

        bss_cell u_cell (
            .aclk   (aclk),
            .ctrl   (cell_ctrl),
            .din    (din),
            .needle (bss_pkg::fold_byte(need_raw, fold_reg)),
            .active (active),
            .dout   (cell_dout[j]),
            .match  (cell_match[j])
        );
    end

    assign hit = &cell_match;

    // Decision for the byte at the input, in priority order: empty needle,
    // overlong buffer, NUL terminator, completed match, end of buffer.
    always_comb begin
        done        = 1'b0;
        outcome_now = bss_pkg::OUTCOME_NOT_FOUND;
        if (n_zero) begin
            done        = 1'b1;
            outcome_now = bss_pkg::OUTCOME_FOUND;
        end else if (overlong) begin
            done        = 1'b1;
            outcome_now = bss_pkg::OUTCOME_OVERLONG;
        end else if (hay_nul) begin
            done        = 1'b1;
            outcome_now = bss_pkg::OUTCOME_NOT_FOUND;
        end else if (hit && reached) begin
            done        = 1'b1;
            outcome_now = bss_pkg::OUTCOME_FOUND;
        end else if (s_tlast) begin
            done        = 1'b1;
            outcome_now = bss_pkg::OUTCOME_NOT_FOUND;
        end
    end

    always_comb begin
        position_next = position_reg;
        decided_next  = decided_reg;
        m_valid_next  = m_valid_reg;
        outcome_next  = outcome_reg;
        offset_next   = offset_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            if (s_tlast) begin
                position_next = '0;
                decided_next  = 1'b0;
            end else begin
                if (!overlong) begin
                    position_next = position_reg + POS_W'(1);
                end
                decided_next = decided_reg || done;
            end

            if (!decided_reg && done) begin
                m_valid_next = 1'b1;
                outcome_next = outcome_now;
                // Only a match past the empty-needle case carries a nonzero offset.
                if (outcome_now == bss_pkg::OUTCOME_FOUND && !n_zero) begin
                    offset_next = off_full[bss_pkg::OFFSET_W-1:0];
                end else begin
                    offset_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            decided_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            position_reg <= position_next;
            decided_reg  <= decided_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        outcome_reg <= outcome_next;
        offset_reg  <= offset_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = outcome_reg;
    assign m_tdata  = offset_reg;

endmodule

FILE: design/bss_cell.sv
// One cell of the haystack window: holds one folded byte and compares the byte
// entering it against its aligned needle byte. Depends on bss_pkg.
module bss_cell (
    input  logic                aclk,
    input  bss_pkg::cell_ctrl_t ctrl,
    input  bss_pkg::byte_t      din,
    input  bss_pkg::byte_t      needle,
    input  logic                active,
    output bss_pkg::byte_t      dout,
    output logic                match
);

    bss_pkg::byte_t win_reg;
    bss_pkg::byte_t win_next;

    always_comb begin
        win_next = win_reg;
        if (ctrl.clear) begin
            win_next = bss_pkg::CHAR_NUL;
        end else if (ctrl.shift) begin
            win_next = din;
        end
    end

    // The window is part of the buffer state, so clear it explicitly at buffer end;
    // reset is handled by the top level issuing a clear.
    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    // A cell beyond the needle length never blocks a hit.
    assign match = !active || (din == needle);
    assign dout  = win_reg;

endmodule

FILE: design/bss_checker.sv
// Port-level checker for bounded_substring_search, attached by the bind at the end.
// Depends on bss_pkg and bounded_substring_search_assert.svh.
`include "bounded_substring_search_assert.svh"

module bss_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result keeps its contents.
    `BSS_ASSERT(a_result_held,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
        "result changed while stalled")

    // Only a found result carries an offset.
    `BSS_ASSERT(a_offset_zero,
        m_tvalid && (m_tuser != bss_pkg::OUTCOME_FOUND) |-> (m_tdata == 16'd0),
        "nonzero offset without a match")

    // A new result always follows an input transaction.
    `BSS_ASSERT(a_result_cause,
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready),
        "result without an input transaction")

    // Reset empties the output register.
    `BSS_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind bounded_substring_search bss_checker u_bss_checker (.*);
